/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// All checks are sampled on the rising clock edge and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property check.
`define PIH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Overlapping implication check built on the plain form.
`define PIH_ASSERT_IMP(lbl, ante, cons, msg) \
  `PIH_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* hw/rtl/pih_pkg.sv */
package pih_pkg;

  // Field and datapath widths.
  localparam int CoordW     = 24;
  localparam int DiffW      = CoordW + 1;
  localparam int RadW       = 23;
  localparam int RadSqW     = 2 * RadW;
  localparam int LimW       = 25;
  localparam int NormW      = 16;
  localparam int NormalFrac = 14;
  localparam int ProdW      = DiffW + NormW;
  localparam int ProjW      = ProdW + 1;
  localparam int SqW        = 2 * (DiffW - 1);
  localparam int DistW      = SqW + 1;
  localparam int NumFaces   = 6;
  localparam int RegW       = 32;
  localparam int CfgIdxW    = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegOuter = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInner = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFace0 = 3'd2;

  // One input item.
  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] padding;
  } pih_pt_t;

  // Token handed along the face cell chain.
  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [LimW-1:0]  lim;
    logic                    reject;
    logic signed [ProjW-1:0] best;
  } pih_tok_t;

endpackage

/* hw/rtl/pih_if.sv */
// Input item channel.
interface pih_in_if import pih_pkg::*; ();
  logic    valid;
  logic    ready;
  pih_pt_t pt;

  modport source (output valid, output pt, input ready);
  modport sink (input valid, input pt, output ready);
endinterface

// Result item channel.
interface pih_out_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink (input valid, input inside_res, output ready);
endinterface

/* hw/rtl/pih_front.sv */
module pih_front import pih_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  pih_pt_t               pt_i,
  input  logic [RadW-1:0]       inner_i,
  input  logic [RadSqW-1:0]     r2_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output pih_tok_t              tok_o
);

  logic                    v0_q, v1_q, v2_q;
  logic                    rdy0, rdy1, rdy2;
  logic signed [DiffW-1:0] dx0_q, dy0_q, dx1_q, dy1_q;
  logic signed [LimW-1:0]  lim0_q, lim1_q;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic signed [2*DiffW-1:0] sqx_full, sqy_full;
  logic [DistW-1:0]        d2;
  pih_tok_t                tok_q;

  // Each stage loads when it is empty or its contents move on.
  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign rdy0    = !v0_q || rdy1;
  assign ready_o = rdy0;

  assign sqx_full = dx0_q * dx0_q;
  assign sqy_full = dy0_q * dy0_q;
  assign d2       = {1'b0, sqx_q} + {1'b0, sqy_q};

  // Valid bits for the three front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // Offset and padded inner radius.
  always_ff @(posedge clk_i) begin
    if (rdy0 && valid_i) begin
      dx0_q  <= DiffW'(pt_i.point_x) - DiffW'(pt_i.center_x);
      dy0_q  <= DiffW'(pt_i.point_y) - DiffW'(pt_i.center_y);
      lim0_q <= $signed({2'b00, inner_i}) + LimW'(pt_i.padding);
    end
  end

  // Squares of the offset components; both are below 2**48.
  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      dx1_q  <= dx0_q;
      dy1_q  <= dy0_q;
      lim1_q <= lim0_q;
      sqx_q  <= sqx_full[SqW-1:0];
      sqy_q  <= sqy_full[SqW-1:0];
    end
  end

  // Quick rejection against the squared outer radius.
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      tok_q.dx     <= dx1_q;
      tok_q.dy     <= dy1_q;
      tok_q.lim    <= lim1_q;
      tok_q.reject <= d2 > DistW'(r2_i);
      tok_q.best   <= '0;
    end
  end

  assign valid_o = v2_q;
  assign tok_o   = tok_q;

endmodule

/* hw/rtl/pih_cell.sv */
`include "assert_macros.svh"

module pih_cell import pih_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [RegW-1:0] normal_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  pih_tok_t        tok_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pih_tok_t        tok_o
);

  logic                    va_q, vb_q;
  logic                    rdya, rdyb;
  logic signed [NormW-1:0] nx, ny;
  logic signed [ProdW-1:0] mx, my;
  logic signed [ProdW-1:0] mx_q, my_q;
  logic signed [ProjW-1:0] proj;
  pih_tok_t                toka_q, tokb_q, tokb_d;

  assign nx = $signed(normal_i[NormW-1:0]);
  assign ny = $signed(normal_i[2*NormW-1:NormW]);
  assign mx = $signed(tok_i.dx) * nx;
  assign my = $signed(tok_i.dy) * ny;
  assign proj = ProjW'(mx_q) + ProjW'(my_q);

  assign rdyb    = !vb_q || ready_i;
  assign rdya    = !va_q || rdyb;
  assign ready_o = rdya;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdya) va_q <= valid_i;
      if (rdyb) vb_q <= va_q;
    end
  end

  // Products of the offset with this face's normal.
  always_ff @(posedge clk_i) begin
    if (rdya && valid_i) begin
      toka_q <= tok_i;
      mx_q   <= mx;
      my_q   <= my;
    end
  end

  // Projection and running maximum.
  always_comb begin
    tokb_d = toka_q;
    if (proj > $signed(toka_q.best)) begin
      tokb_d.best = proj;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyb && va_q) begin
      tokb_q <= tokb_d;
    end
  end

  assign valid_o = vb_q;
  assign tok_o   = tokb_q;

  `PIH_ASSERT_IMP(a_best_nonneg, vb_q, !tokb_q.best[ProjW-1], "running maximum went negative")
  `PIH_ASSERT_IMP(a_best_grows, va_q, tokb_d.best >= toka_q.best, "running maximum decreased")
  `PIH_ASSERT_IMP(a_stall_full, !ready_o, va_q && vb_q, "cell stalled with a free stage")

endmodule

/* hw/rtl/point_in_hexagon_test.sv */
// Channel   Dir  Payload                                          Handshake
// pt_i      in   center_x, center_y, point_x, point_y, padding    valid/ready
// res_o     out  inside_res                                       valid/ready
// cfg       in   cfg_idx_i, cfg_data_i                            cfg_we_i
//
// One item is taken per cycle unless a waiting result holds a full pipeline; each
// result passes 3 front stages, 2 stages in each of six face cells, 1 output register.
// Every stage has its own valid bit and loads when empty or draining, so the
// input keeps flowing while a result waits, until all stages are full.
// Reset clears valid bits and configuration registers; there is no clearing pass.
`include "assert_macros.svh"

module point_in_hexagon_test import pih_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pih_in_if.sink             pt_i,
  pih_out_if.source          res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i
);

  logic [RadW-1:0]   outer_q, inner_q;
  logic [RadSqW-1:0] r2_q;
  logic [RegW-1:0]   normal_q [NumFaces];

  logic                    v    [NumFaces+1];
  logic                    rdy  [NumFaces+1];
  pih_tok_t                tok  [NumFaces+1];
  logic signed [ProjW-1:0] limit;
  logic                    out_v_q, inside_q, out_en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= '0;
      inner_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegOuter) outer_q <= cfg_data_i[RadW-1:0];
      if (cfg_idx_i == RegInner) inner_q <= cfg_data_i[RadW-1:0];
    end
  end

  for (genvar k = 0; k < NumFaces; k++) begin : g_norm
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        normal_q[k] <= '0;
      end else if (cfg_we_i && cfg_idx_i == CfgIdxW'(RegFace0 + k)) begin
        normal_q[k] <= cfg_data_i;
      end
    end
  end

  // Squared outer radius, refreshed every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= '0;
    end else begin
      r2_q <= RadSqW'(outer_q) * RadSqW'(outer_q);
    end
  end

  // Offset, squares and quick rejection.
  pih_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pt_i.valid),
    .ready_o (pt_i.ready),
    .pt_i    (pt_i.pt),
    .inner_i (inner_q),
    .r2_i    (r2_q),
    .valid_o (v[0]),
    .ready_i (rdy[0]),
    .tok_o   (tok[0])
  );

  // Chain of face cells, one per hexagon face.
  for (genvar k = 0; k < NumFaces; k++) begin : g_cell
    pih_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .normal_i (normal_q[k]),
      .valid_i  (v[k]),
      .ready_o  (rdy[k]),
      .tok_i    (tok[k]),
      .valid_o  (v[k+1]),
      .ready_i  (rdy[k+1]),
      .tok_o    (tok[k+1])
    );
  end

  // Final face test on the projection scale.
  assign limit = {{(ProjW-LimW-NormalFrac){tok[NumFaces].lim[LimW-1]}},
                  tok[NumFaces].lim, {NormalFrac{1'b0}}};
  assign out_en = !out_v_q || res_o.ready;
  assign rdy[NumFaces] = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= v[NumFaces];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && v[NumFaces]) begin
      inside_q <= !tok[NumFaces].reject && ($signed(tok[NumFaces].best) <= limit);
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.inside_res = inside_q;

  `PIH_ASSERT_IMP(a_stall_cause, !pt_i.ready, res_o.valid && !res_o.ready, "input stalled while output drains")
  `PIH_ASSERT_IMP(a_r2_square, cfg_we_i && cfg_idx_i == RegOuter, ##2 (r2_q == RadSqW'($past(cfg_data_i[RadW-1:0], 2)) * RadSqW'($past(cfg_data_i[RadW-1:0], 2))), "squared outer radius mismatch")
  `PIH_ASSERT_IMP(a_face0_write, cfg_we_i && cfg_idx_i == RegFace0, ##1 (normal_q[0] == $past(cfg_data_i)), "face normal write lost")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import pih_pkg::*;

  localparam int MinC = -(1 << (CoordW - 1));
  localparam int MaxC = (1 << (CoordW - 1)) - 1;

  // Unit normals of a regular hexagon, {y, x} in Q1.14, face 0 on the right.
  localparam logic [NumFaces-1:0][RegW-1:0] HexNormals = {
    32'hC893_2000, 32'hC893_E000, 32'h0000_C000,
    32'h376D_E000, 32'h376D_2000, 32'h0000_4000
  };

  // Q16.8 values used by the directed rows.
  localparam int HexInner = 25600;  // 100.0
  localparam int HexOuter = 29560;  // about 100.0 / cos(30 deg)

  // Scale from inscribed to circumscribed radius, in Q2.14.
  localparam longint OuterScale = 18919;

  localparam int HoldLong = 80;
  localparam int ItemsPerSetup = 220;

  typedef enum bit {RowWrite, RowItem} row_kind_e;
  typedef enum int {SmallHex, LargeHex, RandomRegs, WideOpen, ZeroOuter, NumSetups}
    setup_e;

  // One row of the directed table: a register write or an item.
  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [RegW-1:0]      data;
    pih_pt_t              pt;
    bit                   typed;
    bit                   want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RegW-1:0]    cfg_data;

  pih_in_if  pt_if ();
  pih_out_if res_if ();

  point_in_hexagon_test dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_i       (pt_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Local copy of the configuration, as the block should hold it.
  logic [RadW-1:0]                 outer_rad;
  logic [RadW-1:0]                 inner_rad;
  logic [NumFaces-1:0][RegW-1:0]   normals;

  // Verdicts predicted for accepted items, oldest first, and the directed table.
  bit   inside_q[$];
  row_t plan[$];

  bit tx_calm;
  bit rx_calm;
  bit squeeze_req;
  int n_checked;
  int n_inside;
  int n_fail;
  int n_writes;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Predicts whether a point lies in the padded hexagon for the current setup.
  function automatic bit hex_contains(pih_pt_t p);
    longint dx, dy, d2, r2, best, proj, lim;
    dx = longint'($signed(p.point_x)) - longint'($signed(p.center_x));
    dy = longint'($signed(p.point_y)) - longint'($signed(p.center_y));
    d2 = dx * dx + dy * dy;
    r2 = longint'(outer_rad) * longint'(outer_rad);
    if (d2 > r2) begin
      return 1'b0;
    end
    best = 0;
    for (int f = 0; f < NumFaces; f++) begin
      proj = dx * longint'($signed(normals[f][NormW-1:0]))
           + dy * longint'($signed(normals[f][RegW-1:NormW]));
      if (proj > best) begin
        best = proj;
      end
    end
    lim = (longint'(inner_rad) + longint'($signed(p.padding))) * (longint'(1) << NormalFrac);
    return best <= lim;
  endfunction

  // Idle cycles before the next item; calm stretches have none.
  function automatic int unsigned next_gap(inout bit calm);
    if ($urandom_range(0, 29) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic row_t reg_row(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] data);
    row_t r;
    r = '{kind: RowWrite, idx: idx, data: data, pt: '0, typed: 1'b0, want: 1'b0};
    return r;
  endfunction

  function automatic row_t pt_row(int cx, int cy, int px, int py, int pad,
                                  bit typed = 1'b0, bit want = 1'b0);
    row_t r;
    r = '{kind: RowItem, idx: '0, data: '0,
          pt: '{CoordW'(cx), CoordW'(cy), CoordW'(px), CoordW'(py), CoordW'(pad)},
          typed: typed, want: want};
    return r;
  endfunction

  // Random item: mostly points around the centre within reach of the outer
  // radius, the rest with every field drawn over its full range.
  function automatic pih_pt_t make_item();
    pih_pt_t     p;
    int unsigned mode, span, pspan;
    mode  = $urandom_range(0, 9);
    span  = int'(outer_rad) + int'(outer_rad >> 3) + 2;
    pspan = int'(outer_rad >> 4) + 1;
    p.center_x = CoordW'($urandom);
    p.center_y = CoordW'($urandom);
    p.padding  = CoordW'($urandom);
    if (mode < 2) begin
      p.point_x = CoordW'($urandom);
      p.point_y = CoordW'($urandom);
    end else begin
      p.point_x = p.center_x + CoordW'($urandom_range(0, 2 * span) - span);
      p.point_y = p.center_y + CoordW'($urandom_range(0, 2 * span) - span);
      if (mode > 2) begin
        p.padding = CoordW'($urandom_range(0, 2 * pspan) - pspan);
      end
    end
    return p;
  endfunction

  // Offers one item after an idle gap and records its verdict on acceptance.
  task automatic send_item(pih_pt_t p, bit want, int unsigned gap);
    if (gap != 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt_if.valid <= 1'b1;
    pt_if.pt    <= p;
    do @(posedge clk_i); while (!pt_if.ready);
    inside_q.push_back(want);
  endtask

  // Waits until every accepted item has produced its result.
  task automatic drain();
    while (inside_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it into the local copy.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegOuter: outer_rad = data[RadW-1:0];
      RegInner: inner_rad = data[RadW-1:0];
      default:  normals[idx - RegFace0] = data;
    endcase
    n_writes++;
  endtask

  // Result side: random stalls, one long hold on request, in-order check.
  initial begin
    int unsigned hold;
    bit          want;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = HoldLong;
      end else begin
        hold = next_gap(rx_calm);
      end
      if (hold != 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (inside_q.size() == 0) begin
        n_fail++;
        $display("%0t: result item with none expected, expected none, actual %0b",
                 $time, res_if.inside_res);
      end else begin
        want = inside_q.pop_front();
        n_checked++;
        if (res_if.inside_res === 1'b1) begin
          n_inside++;
        end
        if (res_if.inside_res !== want) begin
          n_fail++;
          $display("%0t: inside_res wrong, expected %0b, actual %0b",
                   $time, want, res_if.inside_res);
        end
      end
    end
  end

  // Stimulus: directed table, then random items under several setups.
  initial begin
    pih_pt_t                        pt;
    bit                             want;
    logic [RegW-1:0]                outer_val;
    logic [RegW-1:0]                inner_val;
    logic [NumFaces-1:0][RegW-1:0]  face_val;
    longint                         ir;
    int unsigned                    gap;

    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    pt_if.valid = 1'b0;
    pt_if.pt    = '0;
    outer_rad   = '0;
    inner_rad   = '0;
    normals     = '0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    squeeze_req = 1'b0;
    n_checked   = 0;
    n_inside    = 0;
    n_fail      = 0;
    n_writes    = 0;

    plan = '{
      // Registers at reset: only a zero offset passes, padding alone decides.
      pt_row(0, 0, 0, 0, 0, 1'b1, 1'b1),
      pt_row(0, 0, 0, 0, -1, 1'b1, 1'b0),
      pt_row(0, 0, 1, 0, 0, 1'b1, 1'b0),
      pt_row(MinC, 0, MaxC, 0, 0, 1'b1, 1'b0),
      pt_row(MaxC, MaxC, MaxC, MaxC, MaxC, 1'b1, 1'b1),
      pt_row(MinC, MinC, MinC, MinC, MinC, 1'b1, 1'b0),
      // Largest outer radius and zero inner radius, both with bits above the width set, and non-unit normals.
      reg_row(RegOuter, 32'hFFFF_FFFF),
      reg_row(RegInner, 32'hFF80_0000),
      reg_row(RegFace0 + 3'd0, 32'h7FFF_7FFF),
      reg_row(RegFace0 + 3'd1, 32'h8000_8000),
      reg_row(RegFace0 + 3'd2, 32'h8000_7FFF),
      reg_row(RegFace0 + 3'd3, 32'h7FFF_8000),
      reg_row(RegFace0 + 3'd4, 32'h0000_7FFF),
      reg_row(RegFace0 + 3'd5, 32'hFFFF_0001),
      pt_row(MinC, MinC, MaxC, MaxC, MaxC),
      pt_row(0, 0, MaxC, 0, 0),
      pt_row(0, 0, MinC, MinC, MinC),
      pt_row(MaxC, MinC, 0, 0, MaxC),
      pt_row(0, 0, 1 << (CoordW - 2), 1 << (CoordW - 2), MaxC),
      // Regular hexagon of inscribed radius 100.
      reg_row(RegOuter, HexOuter),
      reg_row(RegInner, HexInner),
      reg_row(RegFace0 + 3'd0, HexNormals[0]),
      reg_row(RegFace0 + 3'd1, HexNormals[1]),
      reg_row(RegFace0 + 3'd2, HexNormals[2]),
      reg_row(RegFace0 + 3'd3, HexNormals[3]),
      reg_row(RegFace0 + 3'd4, HexNormals[4]),
      reg_row(RegFace0 + 3'd5, HexNormals[5]),
      pt_row(4096, 4096, 4096, 4096, 0),
      pt_row(0, 0, HexInner, 0, 0),
      pt_row(0, 0, HexInner + 1, 0, 0),
      pt_row(0, 0, HexOuter, 0, 0),
      pt_row(0, 0, HexOuter, 0, HexOuter - HexInner),
      pt_row(0, 0, HexOuter + 1, 0, MaxC),
      pt_row(5, 5, 5, 5, -1),
      // All faces look right: points to the left have no positive projection.
      reg_row(RegFace0 + 3'd1, HexNormals[0]),
      reg_row(RegFace0 + 3'd2, HexNormals[0]),
      reg_row(RegFace0 + 3'd3, HexNormals[0]),
      reg_row(RegFace0 + 3'd4, HexNormals[0]),
      reg_row(RegFace0 + 3'd5, HexNormals[0]),
      pt_row(0, 0, -1000, 0, 0),
      pt_row(0, 0, -1000, 0, -HexInner),
      pt_row(0, 0, -1000, 0, -HexInner - 1),
      pt_row(0, 0, 0, -2000, -HexInner)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (plan[r]) begin
      if (plan[r].kind == RowWrite) begin
        pt_if.valid <= 1'b0;
        drain();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        want = plan[r].typed ? plan[r].want : hex_contains(plan[r].pt);
        send_item(plan[r].pt, want, next_gap(tx_calm));
      end
    end

    // Random items, one register setup after another.
    for (int s = 0; s < NumSetups; s++) begin
      pt_if.valid <= 1'b0;
      drain();
      face_val = HexNormals;
      case (setup_e'(s))
        SmallHex: begin
          ir = $urandom_range(1, 4096);
        end
        LargeHex: begin
          ir = $urandom_range(1 << 20, 7_000_000);
        end
        default: begin
          ir = 0;
        end
      endcase
      inner_val = {9'($urandom), 23'(ir)};
      outer_val = {9'($urandom), 23'(((ir * OuterScale) >> NormalFrac) + 1)};
      case (setup_e'(s))
        RandomRegs: begin
          outer_val = $urandom;
          inner_val = $urandom;
          for (int f = 0; f < NumFaces; f++) face_val[f] = $urandom;
        end
        WideOpen: begin
          outer_val = 32'h007F_FFFF;
          inner_val = '0;
          for (int f = 0; f < NumFaces; f++) face_val[f] = $urandom;
        end
        ZeroOuter: begin
          outer_val = '0;
          inner_val = 32'h007F_FFFF;
        end
        default: ;
      endcase
      write_reg(RegOuter, outer_val);
      write_reg(RegInner, inner_val);
      for (int f = 0; f < NumFaces; f++) begin
        write_reg(RegFace0 + CfgIdxW'(f), face_val[f]);
      end

      // The first setup also fills the pipeline against a long output hold.
      if (setup_e'(s) == SmallHex) begin
        squeeze_req = 1'b1;
      end
      for (int n = 0; n < ItemsPerSetup; n++) begin
        pt  = make_item();
        gap = (setup_e'(s) == SmallHex && n < 60) ? 0 : next_gap(tx_calm);
        send_item(pt, hex_contains(pt), gap);
      end
    end

    pt_if.valid <= 1'b0;
    drain();
    repeat (40) @(posedge clk_i);

    $display("Checked %0d results (%0d inside, %0d outside) across %0d register writes,",
             n_checked, n_inside, n_checked - n_inside, n_writes);
    $display("covering reset values, extreme radii and normals, and five random setups.");
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* point_in_hexagon_test.f */
+incdir+hw/rtl
hw/rtl/pih_pkg.sv
hw/rtl/pih_if.sv
hw/rtl/pih_front.sv
hw/rtl/pih_cell.sv
hw/rtl/point_in_hexagon_test.sv
verif/tb_top.sv
